FILE: rtl/core/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types and codes shared by the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Entry field widths
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_SPARE     = 2'd3
    } t_status;

    // Input word
    typedef struct packed {
        t_op                     op;
        logic [KEY_BITS-1:0]     item_key;
        logic [PAYLOAD_BITS-1:0] item_payload;
    } t_req;

    // Output word
    typedef struct packed {
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        t_status                 status;
        logic                    is_empty;
        logic                    is_full;
        logic [7:0]              entry_count;
    } t_rsp;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_ROOT,
        S_DN_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DN_SET,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue held in one synchronous memory.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; each gives exactly one result word.
// Clear and refused requests go straight to the result; peek reads the
// root first. An insert climbs level by level (read parent, compare and
// write), then places the entry and presents the result. A delete reads
// the root and the last entry, then descends level by level (read left
// child, read right child, compare and write; no right read where there
// is no right child), then settles the moved entry and presents the
// result; both are bounded by the heap depth, about eight levels at the
// default capacity. The one read port of the memory forces these steps.
// The result sits in an output register; a new request is taken no
// earlier than the cycle in which a waiting result is taken. The store
// needs no clearing pass: only entries up to the count are ever used.
module binary_min_heap_queue #(
    parameter int CAPACITY     = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  bmhq_pkg::t_req  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output bmhq_pkg::t_rsp  o_data
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    // Heap memory, entries 1..CAPACITY
    logic [EW-1:0] mem [0:CAPACITY];
    logic [EW-1:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    t_state        r_state, n_state;
    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [EW-1:0] r_item, n_item;
    logic [EW-1:0] r_left, n_left;
    logic [EW-1:0] r_ret, n_ret;
    t_status       r_st, n_st;
    logic          r_oval, n_oval;
    t_rsp          r_out, n_out;

    logic [AW:0]   kid2;
    logic [AW-1:0] kid;
    logic [EW-1:0] best;
    logic [KEY_BITS-1:0] ik;

    assign ik      = r_item[EW-1:PAYLOAD_BITS];
    assign o_stall = (r_state != S_IDLE) || (r_oval && i_stall);
    assign o_valid = r_oval;
    assign o_data  = r_out;
    assign kid2    = {r_pos, 1'b0};
    assign kid     = kid2[AW-1:0];

    // State and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oval  <= n_oval;
        end
        r_pos  <= n_pos;
        r_item <= n_item;
        r_left <= n_left;
        r_ret  <= n_ret;
        r_st   <= n_st;
        r_out  <= n_out;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_item  = r_item;
        n_left  = r_left;
        n_ret   = r_ret;
        n_st    = r_st;
        n_oval  = r_oval;
        n_out   = r_out;
        mem_we  = 1'b0;
        mem_wa  = r_pos;
        mem_wd  = r_item;
        mem_ra  = r_pos >> 1;
        best    = r_left;
        if (r_oval && !i_stall) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_ret = '0;
                    n_st  = ST_OK;
                    n_item = {i_data.item_key, i_data.item_payload};
                    case (i_data.op)
                        OP_INSERT: begin
                            if (32'(r_count) >= 32'(CAPACITY)) begin
                                n_st    = ST_OVERFLOW;
                                n_state = S_OUT;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_pos   = r_count + 1'b1;
                                n_state = S_UP_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_OUT;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_st    = ST_UNDERFLOW;
                                n_state = S_OUT;
                            end else begin
                                mem_ra  = AW'(1);
                                n_pos   = (i_data.op == OP_DELETE) ? r_count : AW'(0);
                                n_state = S_DN_ROOT;
                            end
                        end
                    endcase
                end
            end
            // Read parent of the hole
            S_UP_RD: begin
                if (r_pos == AW'(1)) begin
                    mem_we  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    mem_ra  = r_pos >> 1;
                    n_state = S_UP_CMP;
                end
            end
            // Move parent down or drop item here
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (ik < r_rdata[EW-1:PAYLOAD_BITS]) begin
                    mem_wd  = r_rdata;
                    n_pos   = r_pos >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            // Root arrives; r_pos holds the last index for delete, zero for peek
            S_DN_ROOT: begin
                n_ret = r_rdata;
                if (r_pos == '0) begin
                    n_state = S_OUT;
                end else begin
                    mem_ra  = r_pos;
                    n_count = r_count - 1'b1;
                    n_state = S_DN_LAST;
                end
            end
            // Last entry arrives; it moves down from the root
            S_DN_LAST: begin
                n_item = r_rdata;
                n_pos  = AW'(1);
                if (r_count == '0) begin
                    n_state = S_OUT;
                end else begin
                    mem_ra  = AW'(2);
                    n_state = (r_count >= AW'(2)) ? S_DN_RDL : S_DN_CMP;
                    if (r_count < AW'(2)) begin
                        mem_we  = 1'b1;
                        mem_wa  = AW'(1);
                        mem_wd  = r_rdata;
                        n_state = S_OUT;
                    end
                end
            end
            // Left child arrives; fetch right if present
            S_DN_RDL: begin
                n_left = r_rdata;
                if (kid != r_count) begin
                    mem_ra  = kid + 1'b1;
                    n_state = S_DN_RDR;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            // Hold the right child address so it reaches the compare
            S_DN_RDR: begin
                mem_ra  = kid + 1'b1;
                n_state = S_DN_CMP;
            end
            // Pick smaller child, move it up or settle
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (kid != r_count &&
                    r_rdata[EW-1:PAYLOAD_BITS] < r_left[EW-1:PAYLOAD_BITS]) begin
                    best = r_rdata;
                end
                if (best[EW-1:PAYLOAD_BITS] < ik) begin
                    mem_wd = best;
                    n_pos  = (best == r_left && !(kid != r_count &&
                              r_rdata[EW-1:PAYLOAD_BITS] < r_left[EW-1:PAYLOAD_BITS]))
                             ? kid : kid + 1'b1;
                    if ({n_pos, 1'b0} <= {1'b0, r_count}) begin
                        mem_ra  = AW'({n_pos, 1'b0});
                        n_state = S_DN_RDL;
                    end else begin
                        n_state = S_DN_SET;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            // Drop the moving item at the leaf it reached
            S_DN_SET: begin
                mem_we  = 1'b1;
                n_state = S_OUT;
            end
            // Present result
            S_OUT: begin
                if (!r_oval || !i_stall) begin
                    n_oval = 1'b1;
                    n_out.out_key     = r_ret[EW-1:PAYLOAD_BITS];
                    n_out.out_payload = r_ret[PAYLOAD_BITS-1:0];
                    n_out.status      = r_st;
                    n_out.is_empty    = (r_count == '0);
                    n_out.is_full     = (32'(r_count) == 32'(CAPACITY));
                    n_out.entry_count = 8'(r_count);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // A result is never shown with an impossible status
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status != ST_SPARE))
        else $error("bad status");
    // Count never exceeds capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("count beyond capacity");
    // Input is only taken while idle
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> (r_state == S_IDLE))
        else $error("request taken while busy");
`endif

endmodule

FILE: tb/sv/binary_min_heap_queue_tb.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Self-checking bench for the binary min-heap queue: a behavioural heap
// predicts every result word, a scoreboard compares each result field by
// field, and random bursts, gaps and stalls exercise the handshakes.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;
    import bmhq_pkg::*;

    localparam int HEAP_CAP = 255;

    // Scoreboard: behavioural heap plus queue of predicted result words
    class heap_scoreboard;
        logic [15:0] keys [1:HEAP_CAP];
        logic [15:0] pays [1:HEAP_CAP];
        int unsigned fill;
        t_rsp        pending [$];
        int unsigned mismatches;

        function void note_request(t_req rq);
            t_rsp        rs;
            int unsigned pos;
            int unsigned kid;
            logic [15:0] mk;
            logic [15:0] mp;
            rs = '0;
            rs.status = ST_OK;
            case (rq.op)
                OP_INSERT: begin
                    if (fill >= HEAP_CAP) begin
                        rs.status = ST_OVERFLOW;
                    end else begin
                        fill++;
                        pos = fill;
                        while (pos > 1 && rq.item_key < keys[pos/2]) begin
                            keys[pos] = keys[pos/2];
                            pays[pos] = pays[pos/2];
                            pos = pos / 2;
                        end
                        keys[pos] = rq.item_key;
                        pays[pos] = rq.item_payload;
                    end
                end
                OP_DELETE, OP_PEEK: begin
                    if (fill == 0) begin
                        rs.status = ST_UNDERFLOW;
                    end else begin
                        rs.out_key = keys[1];
                        rs.out_payload = pays[1];
                        if (rq.op == OP_DELETE) begin
                            mk = keys[fill];
                            mp = pays[fill];
                            fill--;
                            pos = 1;
                            // sink the former last entry from the root
                            while (fill > 0 && pos * 2 <= fill) begin
                                kid = pos * 2;
                                if (kid != fill && keys[kid+1] < keys[kid]) kid++;
                                if (keys[kid] < mk) begin
                                    keys[pos] = keys[kid];
                                    pays[pos] = pays[kid];
                                    pos = kid;
                                end else begin
                                    break;
                                end
                            end
                            if (fill > 0) begin
                                keys[pos] = mk;
                                pays[pos] = mp;
                            end
                        end
                    end
                end
                default: fill = 0;
            endcase
            rs.is_empty = (fill == 0);
            rs.is_full = (fill == HEAP_CAP);
            rs.entry_count = fill[7:0];
            pending.push_back(rs);
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp_w;
            if (pending.size() == 0) begin
                report(got, '0, "unexpected word");
                return;
            end
            exp_w = pending.pop_front();
            if (got.out_key !== exp_w.out_key || got.out_payload !== exp_w.out_payload ||
                got.status !== exp_w.status || got.is_empty !== exp_w.is_empty ||
                got.is_full !== exp_w.is_full || got.entry_count !== exp_w.entry_count)
                report(got, exp_w, "field differs");
        endfunction

        function void report(t_rsp got, t_rsp exp_w, string why);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: exp key %h pay %h st %0d e%0b f%0b n%0d,",
                    why, exp_w.out_key, exp_w.out_payload, exp_w.status, exp_w.is_empty,
                    exp_w.is_full, exp_w.entry_count,
                    " got key %h pay %h st %0d e%0b f%0b n%0d",
                    got.out_key, got.out_payload,
                    got.status, got.is_empty, got.is_full, got.entry_count);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_data;
    logic o_valid;
    logic i_stall;
    t_rsp o_data;

    heap_scoreboard sb;
    int unsigned    burst_left;

    binary_min_heap_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hold one request word until accepted, with gaps between bursts
    task automatic send_word(t_op op, logic [15:0] k, logic [15:0] p);
        t_req rq;
        int   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
            if (gap != 0) i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        rq.op = op;
        rq.item_key = k;
        rq.item_payload = p;
        i_valid <= 1'b1;
        i_data <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(rq);
    endtask

    // Drop valid and wait for every predicted word
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: check accepted words, stall on its own pattern
    initial begin
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
            cyc++;
            if ((cyc / 300) % 3 == 0) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Stimulus
    initial begin
        int unsigned r;
        sb = new();
        burst_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty cases, extremes, equal keys, full heap
        send_word(OP_DELETE, 16'h0000, 16'h0000);
        send_word(OP_PEEK, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'h0000, 16'h0000);
        send_word(OP_INSERT, 16'h0000, 16'h1234);
        send_word(OP_INSERT, 16'h8000, 16'h5555);
        send_word(OP_INSERT, 16'h8000, 16'hAAAA);
        send_word(OP_PEEK, 16'h0000, 16'h0000);
        repeat (6) send_word(OP_DELETE, 16'h0000, 16'h0000);
        send_word(OP_INSERT, 16'h0001, 16'h0001);
        send_word(OP_CLEAR, 16'hFFFF, 16'hFFFF);
        send_word(OP_CLEAR, 16'h0000, 16'h0000);
        repeat (HEAP_CAP)
            send_word(OP_INSERT, 16'($urandom_range(0, 15)), 16'($urandom));
        send_word(OP_INSERT, 16'h0000, 16'hBEEF);
        repeat (5) send_word(OP_DELETE, 16'h0000, 16'h0000);
        send_word(OP_CLEAR, 16'h0000, 16'h0000);

        // Pause until every expected word has come back
        drain_results();

        // Random: phases leaning to fill or drain, some narrow key ranges
        for (int i = 0; i < 370; i++) begin
            r = $urandom_range(0, 99);
            if (((i / 100) % 2) == 0 ? r < 65 : r < 35)
                send_word(OP_INSERT,
                          (i % 3 == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom),
                          16'($urandom));
            else if (r < 88)
                send_word(OP_DELETE, 16'($urandom), 16'($urandom));
            else if (r < 98)
                send_word(OP_PEEK, 16'($urandom), 16'($urandom));
            else
                send_word(OP_CLEAR, 16'($urandom), 16'($urandom));
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("binary_min_heap_queue: match");
        else
            $display("binary_min_heap_queue: mismatch");
        $finish;
    end

    // Timeout guard
    initial begin
        #3000000;
        $display("binary_min_heap_queue: mismatch");
        $finish;
    end

endmodule
